[sv/e2sp_pkg.sv]
// Package for the single-precision 2^x unit: formats, lane type and coefficient table.
`timescale 1ns / 1ps
`default_nettype none
package e2sp_pkg;

    // Fraction bits of every fixed-point value in the datapath.
    localparam int FRAC_BITS = 28;
    // Horner accumulator width: covers values in [-4.0, 4.0), signed.
    localparam int PW        = FRAC_BITS + 3;
    // Magnitude of the argument in fixed point (|x| < 128).
    localparam int MW        = FRAC_BITS + 7;
    // Width of the rounding sum x + 0.5.
    localparam int XW        = FRAC_BITS + 9;
    // Integer part k in [-128, 128].
    localparam int KW        = 9;
    // Biased result exponent, signed.
    localparam int EW        = 10;
    localparam int MAN_W     = 23;
    // Number of Horner cells: five coefficient steps plus the final add of 1.0.
    localparam int NCELL     = 6;

    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [31:0] PINF_BITS = 32'h7F80_0000;

    // What the packing stage must do with a lane.
    typedef enum logic [1:0] {
        KIND_NORM = 2'd0,
        KIND_NAN  = 2'd1,
        KIND_OVF  = 2'd2,
        KIND_UNF  = 2'd3
    } kind_t;

    // Data handed from one cell to the next.
    typedef struct packed {
        kind_t                        kind;
        logic signed [KW-1:0]         k;
        logic signed [FRAC_BITS-1:0]  f;
        logic signed [PW-1:0]         p;
    } lane_t;

    // Coefficients as exact single-precision values man * 2^-pw, highest degree first.
    // The last entry is 1.0, the constant term.
    localparam logic [23:0] COEF_MAN [7] = '{
        24'hA0FDDE, 24'hAF9F29, 24'h9D96A6, 24'hE35774,
        24'hF5FDEE, 24'hB17218, 24'h800000
    };
    localparam int COEF_PW [7] = '{36, 33, 30, 28, 26, 24, 23};

    // Coefficient in the datapath format, rounded to nearest with halves up.
    function automatic logic signed [PW-1:0] coef_fixed(input logic [2:0] idx);
        logic [63:0] m;
        int          sh;
        m  = 64'(COEF_MAN[idx]);
        sh = FRAC_BITS - COEF_PW[idx];
        if (sh >= 0) begin
            return PW'(m << sh);
        end
        return PW'((m + (64'd1 << (-sh - 1))) >> (-sh));
    endfunction

endpackage
`default_nettype wire

[sv/e2sp_decode.sv]
// Decode cell: classifies the argument and splits it into integer k and fraction f.
`timescale 1ns / 1ps
`default_nettype none
module e2sp_decode (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [31:0]     x_bits,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output e2sp_pkg::lane_t      out_lane
);

    logic                                     sign;
    logic [7:0]                               ex;
    logic [22:0]                              fr;
    logic [23:0]                              m;
    logic [7:0]                               e_val;
    logic [7:0]                               sh;
    logic [23+e2sp_pkg::FRAC_BITS:0]          wide;
    logic [e2sp_pkg::MW-1:0]                  mag;
    logic signed [e2sp_pkg::XW-1:0]           xf;
    logic signed [e2sp_pkg::XW-1:0]           t;
    e2sp_pkg::lane_t                          lane;
    logic                                     valid_reg;
    logic                                     valid_next;
    e2sp_pkg::lane_t                          lane_reg;

    always_comb begin
        sign  = x_bits[31];
        ex    = x_bits[30:23];
        fr    = x_bits[22:0];
        m     = {(ex != 8'd0), fr};
        e_val = (ex != 8'd0) ? ex : 8'd1;
        // Scaling by 2^(e-150+FRAC_BITS) written as one right shift of m * 2^FRAC_BITS.
        sh    = 8'd150 - e_val;
        wide  = {m, {e2sp_pkg::FRAC_BITS{1'b0}}} >> sh;
        mag   = wide[e2sp_pkg::MW-1:0];
        xf    = sign ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        // Rounding to nearest: k = floor(x + 0.5), f = x - k.
        t     = xf + $signed(e2sp_pkg::XW'(64'd1 << (e2sp_pkg::FRAC_BITS - 1)));

        lane.k = t[e2sp_pkg::XW-1:e2sp_pkg::FRAC_BITS];
        lane.f = {~t[e2sp_pkg::FRAC_BITS-1], t[e2sp_pkg::FRAC_BITS-2:0]};
        lane.p = e2sp_pkg::coef_fixed(3'd0);
        if (ex == 8'hFF && fr != 23'd0) begin
            lane.kind = e2sp_pkg::KIND_NAN;
        end else if (ex >= 8'd134) begin
            lane.kind = sign ? e2sp_pkg::KIND_UNF : e2sp_pkg::KIND_OVF;
        end else begin
            lane.kind = e2sp_pkg::KIND_NORM;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            lane_reg <= lane;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule
`default_nettype wire

[sv/e2sp_cell.sv]
// Horner cell: one truncating fixed-point multiply by f and one coefficient add.
`timescale 1ns / 1ps
`default_nettype none
module e2sp_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic signed [e2sp_pkg::PW-1:0] coef,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire e2sp_pkg::lane_t               in_lane,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output e2sp_pkg::lane_t                    out_lane
);

    logic [e2sp_pkg::PW-2:0]                       pa;
    logic [e2sp_pkg::FRAC_BITS-1:0]                fa;
    logic [e2sp_pkg::PW+e2sp_pkg::FRAC_BITS-2:0]   prod;
    logic [e2sp_pkg::PW-2:0]                       q;
    logic                                          neg;
    logic signed [e2sp_pkg::PW-1:0]                qs;
    e2sp_pkg::lane_t                               lane;
    logic                                          valid_reg;
    logic                                          valid_next;
    e2sp_pkg::lane_t                               lane_reg;

    // The product is formed on magnitudes so that truncation goes toward zero.
    always_comb begin
        pa   = in_lane.p[e2sp_pkg::PW-1] ? (e2sp_pkg::PW-1)'(-in_lane.p)
                                         : in_lane.p[e2sp_pkg::PW-2:0];
        fa   = in_lane.f[e2sp_pkg::FRAC_BITS-1] ? e2sp_pkg::FRAC_BITS'(-in_lane.f)
                                                : in_lane.f;
        neg  = in_lane.p[e2sp_pkg::PW-1] ^ in_lane.f[e2sp_pkg::FRAC_BITS-1];
        prod = (e2sp_pkg::PW+e2sp_pkg::FRAC_BITS-1)'(pa) *
               (e2sp_pkg::PW+e2sp_pkg::FRAC_BITS-1)'(fa);
        q    = prod[e2sp_pkg::PW+e2sp_pkg::FRAC_BITS-2:e2sp_pkg::FRAC_BITS];
        qs   = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        lane      = in_lane;
        lane.p    = qs + coef;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            lane_reg <= lane;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule
`default_nettype wire

[sv/e2sp_pack.sv]
// Packing cell: normalizes the polynomial value, applies k and holds the result item.
`timescale 1ns / 1ps
`default_nettype none
module e2sp_pack (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire e2sp_pkg::lane_t  in_lane,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [31:0]           m_y_bits,
    output logic                  m_overflow,
    output logic                  m_underflow
);

    logic signed [e2sp_pkg::PW-1:0]  y;
    logic                            lead_hi;
    logic [e2sp_pkg::MAN_W-1:0]      man;
    logic signed [e2sp_pkg::EW-1:0]  bexp;
    logic [31:0]                     y_bits;
    logic                            ovf;
    logic                            unf;
    logic                            valid_reg;
    logic                            valid_next;
    logic [31:0]                     y_bits_reg;
    logic                            ovf_reg;
    logic                            unf_reg;

    // 2^f for f in [-0.5, 0.5) lies in [0.70, 1.42), so the leading one sits
    // either at the units bit or just below it.
    always_comb begin
        y       = in_lane.p;
        lead_hi = y[e2sp_pkg::FRAC_BITS];
        man     = lead_hi ? y[e2sp_pkg::FRAC_BITS-1 -: e2sp_pkg::MAN_W]
                          : y[e2sp_pkg::FRAC_BITS-2 -: e2sp_pkg::MAN_W];
        bexp    = e2sp_pkg::EW'(in_lane.k) + 10'sd127 - (lead_hi ? 10'sd0 : 10'sd1);
        y_bits  = 32'd0;
        ovf     = 1'b0;
        unf     = 1'b0;
        unique case (in_lane.kind)
            e2sp_pkg::KIND_NAN: begin
                y_bits = e2sp_pkg::QNAN_BITS;
            end
            e2sp_pkg::KIND_OVF: begin
                y_bits = e2sp_pkg::PINF_BITS;
                ovf    = 1'b1;
            end
            e2sp_pkg::KIND_UNF: begin
                unf = 1'b1;
            end
            default: begin
                if (y <= 0 || bexp <= 0) begin
                    unf = 1'b1;
                end else if (bexp >= 10'sd255) begin
                    y_bits = e2sp_pkg::PINF_BITS;
                    ovf    = 1'b1;
                end else begin
                    y_bits = {1'b0, bexp[7:0], man};
                end
            end
        endcase
    end

    assign in_ready   = !valid_reg || m_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            y_bits_reg <= y_bits;
            ovf_reg    <= ovf;
            unf_reg    <= unf;
        end
    end

    assign m_valid     = valid_reg;
    assign m_y_bits    = y_bits_reg;
    assign m_overflow  = ovf_reg;
    assign m_underflow = unf_reg;

endmodule
`default_nettype wire

[sv/exp2_single_polynomial.sv]
// Top level of the single-precision 2^x unit: decode cell, Horner cell chain, packing cell.
// The unit takes one IEEE single-precision argument x per item and returns 2^x as a
// single-precision value with overflow and underflow flags. It accepts one item in
// every cycle while the output is not stalled. Each item is registered in turn in the
// decode cell, in each of the six Horner cells (each holds one multiplier) and in the
// packing cell, which is also the output register. Every cell has its own valid
// bit and stalls only when the cell after it is full, so items keep entering while a
// result waits at the output, until the chain is filled.
// The argument is rounded to the nearest integer k, leaving a fraction f in
// [-0.5, 0.5); 2^f comes from a degree-6 polynomial in 28-fraction-bit fixed point
// with each product truncated toward zero, and k is added to the exponent.
// A NaN returns the quiet NaN 0x7FC00000. Results whose exponent would reach 255
// saturate to +infinity with overflow set; results whose exponent would be 0 or
// less are flushed to +0 with underflow set, as no denormals are produced.
`timescale 1ns / 1ps
`default_nettype none
module exp2_single_polynomial (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_x_bits,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_y_bits,
    output logic             m_overflow,
    output logic             m_underflow
);

    // Link j runs from the cell before into Horner cell j; link NCELL feeds the packer.
    logic            link_valid [e2sp_pkg::NCELL+1];
    logic            link_ready [e2sp_pkg::NCELL+1];
    e2sp_pkg::lane_t link_lane  [e2sp_pkg::NCELL+1];

    // The decode cell classifies the argument and starts the sum at the
    // highest-degree coefficient.
    e2sp_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .x_bits    (s_x_bits),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_lane  (link_lane[0])
    );

    // Each Horner cell multiplies the running sum by f and adds the next
    // coefficient; the last one adds 1.0.
    for (genvar j = 0; j < e2sp_pkg::NCELL; j++) begin : g_cell
        e2sp_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .coef      (e2sp_pkg::coef_fixed(3'(j + 1))),
            .in_valid  (link_valid[j]),
            .in_ready  (link_ready[j]),
            .in_lane   (link_lane[j]),
            .out_valid (link_valid[j+1]),
            .out_ready (link_ready[j+1]),
            .out_lane  (link_lane[j+1])
        );
    end

    // The packer turns the value of 2^f and k into the result item.
    e2sp_pack u_pack (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (link_valid[e2sp_pkg::NCELL]),
        .in_ready    (link_ready[e2sp_pkg::NCELL]),
        .in_lane     (link_lane[e2sp_pkg::NCELL]),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_y_bits    (m_y_bits),
        .m_overflow  (m_overflow),
        .m_underflow (m_underflow)
    );

endmodule
`default_nettype wire

[sv/e2sp_checker.sv]
// Port checker for the single-precision 2^x unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module e2sp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_y_bits,
    input wire logic        m_overflow,
    input wire logic        m_underflow
);

    // Reset empties the chain, so no result is offered right after it.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered after reset");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_y_bits) && $stable(m_overflow)
                                && $stable(m_underflow))
        else $error("stalled result changed");

    // The two flags never appear together.
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_overflow && m_underflow))
        else $error("overflow and underflow both set");

    // An overflow always comes with +infinity.
    a_ovf_inf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> m_y_bits == e2sp_pkg::PINF_BITS)
        else $error("overflow without infinity");

    // An underflow always comes with +0.
    a_unf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_underflow |-> m_y_bits == 32'd0)
        else $error("underflow without zero");

endmodule

bind exp2_single_polynomial e2sp_checker u_e2sp_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_y_bits    (m_y_bits),
    .m_overflow  (m_overflow),
    .m_underflow (m_underflow)
);
`default_nettype wire
